FILE: src/amhpf_pkg.sv
package amhpf_pkg;

  // Defaults for the top-level parameters.
  localparam int DEFAULT_WINDOW_SIZE  = 512;
  localparam int DEFAULT_SAMPLE_WIDTH = 16;

  // Fixed field widths of the result and of the coefficient register.
  localparam int ALPHA_W   = 16;
  localparam int MAG_W     = 24;
  localparam int FILT_W    = 25;
  localparam int POS_OUT_W = 9;
  localparam int FRAC_W    = 8;

  // Coefficient after reset, about 0.091 in unsigned 0.16.
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd5964;

  // Magnitude saturation limit.
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // Depth of the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;

  // Window bookkeeping that travels with each sample.
  typedef struct packed {
    logic [POS_OUT_W-1:0] position;
    logic                 last;
  } amhpf_tag_t;

  // Push request from the front end into the queue.
  typedef struct packed {
    logic       valid;
    amhpf_tag_t tag;
  } amhpf_push_t;

endpackage

FILE: src/amhpf_front.sv
module amhpf_front
  import amhpf_pkg::*;
#(
  parameter int WINDOW_SIZE  = DEFAULT_WINDOW_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        queue_full,
  output amhpf_push_t push
);

  localparam int POS_W = $clog2(WINDOW_SIZE);

  logic [POS_W-1:0]   fill_position;
  logic [POS_W+8:0]   pos_ext;
  logic               last;
  logic               accept;

  // A new transaction is taken whenever the queue has room.
  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Classify the sample: its place in the window and whether it closes it.
  assign last    = (fill_position == POS_W'(WINDOW_SIZE - 1));
  assign pos_ext = {{POS_OUT_W{1'b0}}, fill_position};

  assign push.valid        = accept;
  assign push.tag.position = pos_ext[POS_OUT_W-1:0];
  assign push.tag.last     = last;

  // Window fill counter, wrapping after the last sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_position <= '0;
    end else if (accept) begin
      fill_position <= last ? '0 : fill_position + 1'b1;
    end
  end

endmodule

FILE: src/amhpf_queue.sv
module amhpf_queue
  import amhpf_pkg::*;
#(
  parameter int WIDTH = 3 * DEFAULT_SAMPLE_WIDTH + $bits(amhpf_tag_t)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/amhpf_back.sv
module amhpf_back
  import amhpf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write_en,
  input  logic [ALPHA_W-1:0]      cfg_write_data,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  logic [SAMPLE_WIDTH-1:0] q_x,
  input  logic [SAMPLE_WIDTH-1:0] q_y,
  input  logic [SAMPLE_WIDTH-1:0] q_z,
  input  amhpf_tag_t              q_tag,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FILT_W-1:0]       filtered_sample,
  output logic [MAG_W-1:0]        vector_magnitude,
  output logic [POS_OUT_W-1:0]    window_position,
  output logic                    window_last
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int SUMW  = 2 * SW;
  localparam int RADW  = SUMW + 2 * FRAC_W;
  localparam int RW    = SW + FRAC_W;
  localparam int CNT_W = $clog2(RW);
  localparam int SUM_W = FILT_W + 2;
  localparam int PROD_W = SUM_W + ALPHA_W + 1;
  localparam int FR_W  = PROD_W - ALPHA_W;

  localparam logic signed [FR_W-1:0] FILT_HI = FR_W'(16777215);
  localparam logic signed [FR_W-1:0] FILT_LO = -(FR_W'(16777216));

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_ROOT   = 6'b000100,
    ST_SUM    = 6'b001000,
    ST_MUL    = 6'b010000,
    ST_SAT    = 6'b100000
  } state_t;

  state_t                    state;
  logic [ALPHA_W-1:0]        filter_alpha;
  logic [SW-1:0]             smp_x;
  logic [SW-1:0]             smp_y;
  logic [SW-1:0]             smp_z;
  amhpf_tag_t                tag;
  logic [CNT_W-1:0]          cnt;
  logic [SUMW-1:0]           acc;
  logic [RADW-1:0]           rad;
  logic [RW+1:0]             rem;
  logic [RW-1:0]             root;
  logic [MAG_W-1:0]          mag;
  logic signed [SUM_W-1:0]   sum;
  logic signed [PROD_W-1:0]  prod;
  logic [MAG_W-1:0]          previous_magnitude;
  logic [FILT_W-1:0]         previous_filtered;

  logic [SW-1:0]             sel;
  logic [SW-1:0]             sel_abs;
  logic [SUMW-1:0]           sq;
  logic [SUMW-1:0]           acc_add;
  logic [RW+3:0]             rem_sh;
  logic [RW+3:0]             trial;
  logic [RW+3:0]             diff;
  logic                      ge;
  logic [RW+MAG_W-1:0]       root_ext;
  logic [MAG_W-1:0]          mag_sat;
  logic signed [FR_W-1:0]    filt_raw;
  logic [FILT_W-1:0]         filt_sat;
  logic                      out_free;

  // Square of one axis per cycle on a shared multiplier.
  always_comb begin
    case (cnt[1:0])
      2'd0:    sel = smp_x;
      2'd1:    sel = smp_y;
      default: sel = smp_z;
    endcase
  end
  assign sel_abs = sel[SW-1] ? (~sel + 1'b1) : sel;
  assign sq      = sel_abs * sel_abs;
  assign acc_add = acc + sq;

  // One root digit per cycle, restoring method.
  assign rem_sh = {rem, rad[RADW-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  // Magnitude saturation to the 24-bit field.
  assign root_ext = {{MAG_W{1'b0}}, root};
  assign mag_sat  = (root_ext > {{RW{1'b0}}, MAG_MAX}) ? MAG_MAX : root_ext[MAG_W-1:0];

  // Shift down with rounding toward minus infinity, then saturate.
  assign filt_raw = prod[PROD_W-1:ALPHA_W];
  always_comb begin
    if (filt_raw > FILT_HI) begin
      filt_sat = FILT_HI[FILT_W-1:0];
    end else if (filt_raw < FILT_LO) begin
      filt_sat = FILT_LO[FILT_W-1:0];
    end else begin
      filt_sat = filt_raw[FILT_W-1:0];
    end
  end

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  // Coefficient register.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_alpha <= ALPHA_RESET;
    end else if (cfg_write_en) begin
      filter_alpha <= cfg_write_data;
    end
  end

  // Sequencer and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      previous_magnitude <= '0;
      previous_filtered  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          if (cnt == CNT_W'(2)) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (cnt == CNT_W'(RW - 1)) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_SAT;
        end
        ST_SAT: begin
          if (out_free) begin
            previous_magnitude <= mag;
            previous_filtered  <= filt_sat;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        smp_x <= q_x;
        smp_y <= q_y;
        smp_z <= q_z;
        tag   <= q_tag;
        cnt   <= '0;
        acc   <= '0;
      end
      ST_SQUARE: begin
        acc <= acc_add;
        if (cnt == CNT_W'(2)) begin
          rad  <= {acc_add, {(2 * FRAC_W){1'b0}}};
          rem  <= '0;
          root <= '0;
          cnt  <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      ST_ROOT: begin
        rad  <= rad << 2;
        rem  <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
        root <= {root[RW-2:0], ge};
        cnt  <= cnt + 1'b1;
      end
      ST_SUM: begin
        mag <= mag_sat;
        sum <= $signed({{2{previous_filtered[FILT_W-1]}}, previous_filtered})
             + $signed({2'b00, 1'b0, mag_sat})
             - $signed({2'b00, 1'b0, previous_magnitude});
      end
      ST_MUL: begin
        prod <= sum * $signed({1'b0, filter_alpha});
      end
      default: begin
      end
    endcase
  end

  // Output register: the result holds until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_SAT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SAT && out_free) begin
      filtered_sample  <= filt_sat;
      vector_magnitude <= mag;
      window_position  <= tag.position;
      window_last      <= tag.last;
    end
  end

endmodule

FILE: src/accel_magnitude_highpass_framer_core.sv
// Accelerometer magnitude high-pass framer.
// Input channel (in_valid/in_ready) takes one three-axis sample per
// transaction; the output channel (out_valid/out_ready) gives one result per
// sample: the 16.8 vector magnitude, the high-passed magnitude in signed 16.8
// with saturation, and the sample's window position with a last flag.
// The coefficient filter_alpha (unsigned 0.16) is written through
// cfg_write_en/cfg_write_data; the user must write it only while the block
// is idle, and the block itself does not enforce this. From the queue to the
// output register a sample is squared axis by axis on the shared multiplier,
// goes through the square root at one digit per cycle, then through the sum,
// multiply and saturate stages. The back end works on one sample at a time
// and takes the next from the queue only when idle. A two-entry queue takes
// new samples while the back end works or while a result waits; in_ready
// drops only when that queue is full. A stalled receiver holds the result in
// the output register and the back end waits. Reset (rst, synchronous)
// empties the queue, clears the filter history and the window counter, and
// loads the coefficient default of about 0.091.
module accel_magnitude_highpass_framer_core
  import amhpf_pkg::*;
#(
  parameter int WINDOW_SIZE  = DEFAULT_WINDOW_SIZE,
  parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write_en,
  input  logic [ALPHA_W-1:0]      cfg_write_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] accel_x,
  input  logic [SAMPLE_WIDTH-1:0] accel_y,
  input  logic [SAMPLE_WIDTH-1:0] accel_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FILT_W-1:0]       filtered_sample,
  output logic [MAG_W-1:0]        vector_magnitude,
  output logic [POS_OUT_W-1:0]    window_position,
  output logic                    window_last
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int TAGW = $bits(amhpf_tag_t);
  localparam int QW   = 3 * SW + TAGW;

  amhpf_push_t    push;
  logic           queue_full;
  logic           q_valid;
  logic           q_pop;
  logic [QW-1:0]  push_data;
  logic [QW-1:0]  pop_data;
  amhpf_tag_t     q_tag;

  // Front end: handshake and window classification.
  amhpf_front #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .queue_full (queue_full),
    .push       (push)
  );

  assign push_data = {push.tag, accel_z, accel_y, accel_x};

  // Queue decoupling front and back end.
  amhpf_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push.valid),
    .push_data (push_data),
    .full      (queue_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_data  (pop_data)
  );

  assign q_tag = pop_data[QW-1 -: TAGW];

  // Back end: magnitude, filter and output register.
  amhpf_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_x              (pop_data[SW-1:0]),
    .q_y              (pop_data[2*SW-1:SW]),
    .q_z              (pop_data[3*SW-1:2*SW]),
    .q_tag            (q_tag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .filtered_sample  (filtered_sample),
    .vector_magnitude (vector_magnitude),
    .window_position  (window_position),
    .window_last      (window_last)
  );

endmodule

FILE: src/amhpf_checker.sv
module amhpf_checker
  import amhpf_pkg::*;
#(
  parameter int WINDOW_SIZE = DEFAULT_WINDOW_SIZE
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [FILT_W-1:0]    filtered_sample,
  input logic [MAG_W-1:0]     vector_magnitude,
  input logic [POS_OUT_W-1:0] window_position,
  input logic                 window_last
);

  localparam logic [POS_OUT_W-1:0] LAST_POS = POS_OUT_W'(WINDOW_SIZE - 1);

  // A stalled result stays valid; its sample, magnitude and position hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_sample)
      && $stable(vector_magnitude) && $stable(window_position))
    else $error("stalled result changed");

  // The last flag marks only the final position of the window.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_last |-> window_position == LAST_POS)
    else $error("window_last at wrong position");

  // No result is presented right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A result taken at the last window position restarts at position zero.
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && window_last |=> !out_valid || window_position == '0)
    else $error("window position did not wrap");

endmodule

bind accel_magnitude_highpass_framer_core amhpf_checker #(
  .WINDOW_SIZE (WINDOW_SIZE)
) u_amhpf_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .filtered_sample  (filtered_sample),
  .vector_magnitude (vector_magnitude),
  .window_position  (window_position),
  .window_last      (window_last)
);

FILE: test/amhpf_result_checker.sv
module amhpf_result_checker
  import amhpf_pkg::*;
#(
  parameter int WINDOW_SIZE  = DEFAULT_WINDOW_SIZE,
  parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write_en,
  input  logic [ALPHA_W-1:0]      cfg_write_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] accel_x,
  input  logic [SAMPLE_WIDTH-1:0] accel_y,
  input  logic [SAMPLE_WIDTH-1:0] accel_z,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [FILT_W-1:0]       filtered_sample,
  input  logic [MAG_W-1:0]        vector_magnitude,
  input  logic [POS_OUT_W-1:0]    window_position,
  input  logic                    window_last,
  output int                      fail_count,
  output int                      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FILT_HI = (longint'(1) <<< (FILT_W - 1)) - 1;
  localparam longint FILT_LO = -(longint'(1) <<< (FILT_W - 1));

  typedef struct packed {
    logic [FILT_W-1:0]    filt;
    logic [MAG_W-1:0]     mag;
    logic [POS_OUT_W-1:0] pos;
    logic                 last;
  } hp_result_t;

  // Shadow copy of the coefficient and of the filter history.
  logic [ALPHA_W-1:0] coeff_alpha;
  longint             prev_mag;
  longint             prev_filt;
  int                 fill_count;
  int                 mismatches;
  hp_result_t         pending_results[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    mismatches  = 0;
    coeff_alpha = ALPHA_RESET;
    prev_mag    = 0;
    prev_filt   = 0;
    fill_count  = 0;
  end

  // Square root built one result bit at a time, from the top down.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) begin
        r = t;
      end
    end
    return r;
  endfunction

  // Works out the result of one sample and moves the filter state forward.
  function automatic hp_result_t advance_filter(input logic [SAMPLE_WIDTH-1:0] ax,
                                                input logic [SAMPLE_WIDTH-1:0] ay,
                                                input logic [SAMPLE_WIDTH-1:0] az);
    longint          sx;
    longint          sy;
    longint          sz;
    longint          energy;
    longint          sum;
    longint          prod;
    longint          filt;
    longint unsigned mag;
    hp_result_t      res;
    sx = longint'($signed(ax));
    sy = longint'($signed(ay));
    sz = longint'($signed(az));
    energy = sx * sx + sy * sy + sz * sz;
    mag = floor_sqrt(longint'(energy) << 16);
    if (mag > longint'(MAG_MAX)) begin
      mag = longint'(MAG_MAX);
    end
    sum  = prev_filt + longint'(mag) - prev_mag;
    prod = sum * longint'(coeff_alpha);
    // An arithmetic shift of a signed value rounds toward minus infinity.
    filt = prod >>> 16;
    if (filt > FILT_HI) begin
      filt = FILT_HI;
    end
    if (filt < FILT_LO) begin
      filt = FILT_LO;
    end
    res.filt = filt[FILT_W-1:0];
    res.mag  = mag[MAG_W-1:0];
    res.pos  = fill_count[POS_OUT_W-1:0];
    res.last = (fill_count >= WINDOW_SIZE - 1);
    prev_mag   = longint'(mag);
    prev_filt  = filt;
    fill_count = res.last ? 0 : fill_count + 1;
    return res;
  endfunction

  // Track configuration writes, predict each input transaction and compare
  // each output transaction with the oldest prediction.
  always @(posedge clk) begin
    hp_result_t seen;
    hp_result_t want;
    if (rst) begin
      coeff_alpha = ALPHA_RESET;
      prev_mag    = 0;
      prev_filt   = 0;
      fill_count  = 0;
      pending_results.delete();
    end else begin
      if (cfg_write_en) begin
        coeff_alpha = cfg_write_data;
      end
      if (out_valid && out_ready) begin
        seen = '{filtered_sample, vector_magnitude, window_position, window_last};
        if (pending_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("Unexpected result: filtered %0d magnitude %0d position %0d last %0b",
                     $signed(seen.filt), seen.mag, seen.pos, seen.last);
          end
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (seen !== want) begin
            if (mismatches < 10) begin
              $display("Mismatch: filtered %0d/%0d magnitude %0d/%0d position %0d/%0d last %0b/%0b",
                       $signed(want.filt), $signed(seen.filt), want.mag, seen.mag,
                       want.pos, seen.pos, want.last, seen.last);
              $display("  (values given as expected/actual)");
            end
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(advance_filter(accel_x, accel_y, accel_z));
      end
    end
    outstanding <= pending_results.size();
    fail_count  <= mismatches;
  end

endmodule

FILE: test/tb_accel_magnitude_highpass_framer_core.sv
module tb_accel_magnitude_highpass_framer_core
  import amhpf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_SIZE    = DEFAULT_WINDOW_SIZE;
  localparam int SAMPLE_WIDTH   = DEFAULT_SAMPLE_WIDTH;
  localparam int IDLE_LIMIT     = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 255;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write_en = 1'b0;
  logic [ALPHA_W-1:0]      cfg_write_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [SAMPLE_WIDTH-1:0] accel_x = '0;
  logic [SAMPLE_WIDTH-1:0] accel_y = '0;
  logic [SAMPLE_WIDTH-1:0] accel_z = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [FILT_W-1:0]       filtered_sample;
  logic [MAG_W-1:0]        vector_magnitude;
  logic [POS_OUT_W-1:0]    window_position;
  logic                    window_last;

  int   fail_count;
  int   outstanding;
  int   samples_sent = 0;
  int   idle_cycles = 0;
  int   alpha_settings = 0;
  logic steady = 1'b0;

  always #10 clk = ~clk;

  accel_magnitude_highpass_framer_core #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .accel_x         (accel_x),
    .accel_y         (accel_y),
    .accel_z         (accel_z),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .filtered_sample (filtered_sample),
    .vector_magnitude(vector_magnitude),
    .window_position (window_position),
    .window_last     (window_last)
  );

  amhpf_result_checker #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .accel_x         (accel_x),
    .accel_y         (accel_y),
    .accel_z         (accel_z),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .filtered_sample (filtered_sample),
    .vector_magnitude(vector_magnitude),
    .window_position (window_position),
    .window_last     (window_last),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  // The receiver stalls at random, except during the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 37);
  end

  // Watchdog on cycles in which no transaction is accepted on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one sample, after an optional random gap, and returns at the edge
  // where it is accepted.
  task automatic send_sample(input int x, input int y, input int z);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 37) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x  <= x[SAMPLE_WIDTH-1:0];
    accel_y  <= y[SAMPLE_WIDTH-1:0];
    accel_z  <= z[SAMPLE_WIDTH-1:0];
    do begin
      @(posedge clk);
    end while (!in_ready);
    samples_sent++;
  endtask

  // Lets every pending result drain and the pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the coefficient while the block is idle.
  task automatic set_alpha(input logic [ALPHA_W-1:0] value);
    wait_drained();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    alpha_settings++;
  endtask

  // One random sample: full range, small, extreme, or a gravity-like
  // reading with noise.
  task automatic send_random_sample();
    int kind;
    int x;
    int y;
    int z;
    int corners[5];
    corners = '{-32768, 32767, 0, -1, 1};
    kind = $urandom_range(99);
    if (kind < 50) begin
      x = int'($urandom_range(65535)) - 32768;
      y = int'($urandom_range(65535)) - 32768;
      z = int'($urandom_range(65535)) - 32768;
    end else if (kind < 70) begin
      x = int'($urandom_range(600)) - 300;
      y = int'($urandom_range(600)) - 300;
      z = int'($urandom_range(600)) - 300;
    end else if (kind < 85) begin
      x = corners[$urandom_range(4)];
      y = corners[$urandom_range(4)];
      z = corners[$urandom_range(4)];
    end else begin
      x = int'($urandom_range(800)) - 400;
      y = int'($urandom_range(800)) - 400;
      z = 16384 + int'($urandom_range(2000)) - 1000;
    end
    send_sample(x, y, z);
  endtask

  initial begin
    logic [ALPHA_W-1:0] phase_alpha[RANDOM_PHASES];
    phase_alpha = '{16'd0, 16'd1, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000};
    phase_alpha[4] = ALPHA_W'($urandom_range(65535));
    phase_alpha[5] = ALPHA_W'($urandom_range(65535));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed samples with the reset coefficient: zero, the largest
    // magnitudes, a large falling step for a negative filtered value,
    // single axes and small values with exact and inexact roots.
    send_sample(0, 0, 0);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, 32767, 32767);
    send_sample(0, 0, 0);
    send_sample(1, 0, 0);
    send_sample(0, -1, 0);
    send_sample(0, 0, 1);
    send_sample(-32768, 0, 0);
    send_sample(0, 32767, 0);
    send_sample(3, 4, 0);
    send_sample(1, 1, 1);
    send_sample(0, 0, 0);

    // Directed samples with the largest coefficient.
    set_alpha(16'hFFFF);
    send_sample(-32768, -32768, -32768);
    send_sample(0, 0, 0);
    send_sample(32767, -32768, 32767);
    send_sample(-1, -1, -1);
    send_sample(16384, 0, 0);
    send_sample(0, 0, 0);
    send_sample(21845, -21846, 10922);
    send_sample(0, 0, 0);

    // Random phases, each under its own coefficient.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_alpha(phase_alpha[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        steady <= (samples_sent >= 600 && samples_sent < 800);
        send_random_sample();
      end
    end
    steady <= 1'b0;

    wait_drained();
    $display("Summary: %0d samples over %0d coefficient writes (0, 1, 0x8000, 0xFFFF, random)",
             samples_sent, alpha_settings);
    $display("Summary: %0d full analysis windows of %0d samples, %0d mismatches",
             samples_sent / WINDOW_SIZE, WINDOW_SIZE, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/amhpf_pkg.sv
src/amhpf_front.sv
src/amhpf_queue.sv
src/amhpf_back.sv
src/accel_magnitude_highpass_framer_core.sv
src/amhpf_checker.sv
test/amhpf_result_checker.sv
test/tb_accel_magnitude_highpass_framer_core.sv
